@@ design/kwm_pkg.sv @@
// kwm_pkg: shared sizes, codes and types of the k-way sorted run merge
// no dependencies; imported by every module of the block

package kwm_pkg;

    // block sizing
    localparam int NUM_RUNS   = 8;
    localparam int RUN_DEPTH  = 64;
    localparam int KEY_BITS   = 32;

    localparam int RUN_BITS   = $clog2(NUM_RUNS);
    localparam int PTR_BITS   = $clog2(RUN_DEPTH);
    localparam int FILL_BITS  = $clog2(RUN_DEPTH + 1);
    localparam int TOTAL_BITS = $clog2(NUM_RUNS * RUN_DEPTH + 1);
    localparam int MEM_DEPTH  = NUM_RUNS * RUN_DEPTH;
    localparam int ADDR_BITS  = RUN_BITS + PTR_BITS;

    // fixed field widths on the stream ports
    localparam int RUN_ID_W   = 3;
    localparam int KEY_W      = 32;
    localparam int REMAIN_W   = 10;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 48;

    // apb
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // request kinds
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // register index (paddr[2])
    localparam logic CFG_IDX_COMPARE_SIGNED = 1'b0;

    typedef logic [KEY_BITS-1:0] key_t;

    // one accepted request
    typedef struct packed {
        logic                func;
        logic [RUN_ID_W-1:0] run_id;
        logic [KEY_W-1:0]    key_in;
    } item_t;

    // one result
    typedef struct packed {
        logic [REMAIN_W-1:0] remaining;
        logic                rejected;
        logic                found;
        logic [RUN_ID_W-1:0] source_run;
        logic [KEY_W-1:0]    key_out;
    } result_t;

    // run memory access for one cycle
    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        key_t                 wdata;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } mem_req_t;

endpackage

@@ design/k_way_sorted_run_merge_top.sv @@
// k_way_sorted_run_merge_top: stream ports, apb register and output register
// depends on kwm_pkg, kwm_ctrl and kwm_store
// a push goes through ST_PUSH, a pop scans every run head and then ST_LAST and ST_FIN;
// both results then wait in ST_DONE and pass the output register. One request at a time;
// a pop reads one run head per cycle over the single memory read port
// reset: synchronous active-low aresetn empties all runs and clears compare_signed;
// key memory is not cleared, no clearing pass

module k_way_sorted_run_merge_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: run_id[2:0], key_in[34:3], zero pad [39:35]
    input  logic [kwm_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: func[0]
    input  logic [kwm_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: key_out[31:0], source_run[34:32], found[35], rejected[36],
    // remaining[46:37], zero pad [47]
    output logic [kwm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kwm_pkg::PADDR_W-1:0]   paddr,
    input  logic [kwm_pkg::PDATA_W-1:0]   pwdata,
    output logic [kwm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import kwm_pkg::*;

    logic     cmp_signed_reg;
    item_t    in_item;
    mem_req_t mem_req;
    key_t     mem_rd_data;
    logic     res_valid, res_ready;
    result_t  res;
    logic     m_tvalid_reg;
    result_t  m_res_reg;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_signed_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == CFG_IDX_COMPARE_SIGNED)) begin
            cmp_signed_reg <= pwdata[0];
        end
    end
    assign prdata = (paddr[2] == CFG_IDX_COMPARE_SIGNED) ? PDATA_W'(cmp_signed_reg) : '0;

    // input unpacking
    assign in_item.func   = s_tuser[0];
    assign in_item.run_id = s_tdata[RUN_ID_W-1:0];
    assign in_item.key_in = s_tdata[RUN_ID_W +: KEY_W];

    kwm_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_item        (in_item),
        .compare_signed (cmp_signed_reg),
        .mem_req        (mem_req),
        .mem_rd_data    (mem_rd_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    kwm_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_res_reg);

endmodule

@@ design/kwm_store.sv @@
// kwm_store: run key memory, one write and one registered read port
// depends on kwm_pkg

module kwm_store (
    input  logic              aclk,
    input  kwm_pkg::mem_req_t req,
    output kwm_pkg::key_t     rd_data
);
    import kwm_pkg::*;

    key_t mem [MEM_DEPTH];
    key_t rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/kwm_ctrl.sv @@
// kwm_ctrl: run pointers and fill counts, push handling and head scan for pops
// depends on kwm_pkg; drives kwm_store

module kwm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  kwm_pkg::item_t    in_item,
    input  logic              compare_signed,
    output kwm_pkg::mem_req_t mem_req,
    input  kwm_pkg::key_t     mem_rd_data,
    output logic              res_valid,
    input  logic              res_ready,
    output kwm_pkg::result_t  res
);
    import kwm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PUSH = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_LAST = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]            state_reg, state_next;
    item_t                 item_reg, item_next;
    logic [PTR_BITS-1:0]   ptr_reg  [NUM_RUNS];
    logic [PTR_BITS-1:0]   ptr_next [NUM_RUNS];
    logic [FILL_BITS-1:0]  fill_reg  [NUM_RUNS];
    logic [FILL_BITS-1:0]  fill_next [NUM_RUNS];
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [RUN_BITS-1:0]   cnt_reg, cnt_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [RUN_BITS-1:0]   rd_run_reg, rd_run_next;
    logic                  have_reg, have_next;
    key_t                  best_reg, best_next;
    logic [RUN_BITS-1:0]   src_reg, src_next;
    result_t               res_reg, res_next;

    logic [RUN_BITS-1:0]   push_run;
    logic                  push_ok;
    logic [PTR_BITS-1:0]   push_pos;
    key_t                  flip, rank_new, rank_best;

    // push target and order ranks
    assign push_run  = item_reg.run_id[RUN_BITS-1:0];
    assign push_ok   = (int'(item_reg.run_id) < NUM_RUNS)
                       && (fill_reg[push_run] != FILL_BITS'(RUN_DEPTH));
    assign push_pos  = PTR_BITS'(ptr_reg[push_run] + fill_reg[push_run][PTR_BITS-1:0]);
    assign flip      = {compare_signed, {(KEY_BITS-1){1'b0}}};
    assign rank_new  = mem_rd_data ^ flip;
    assign rank_best = best_reg ^ flip;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // next state
    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        ptr_next    = ptr_reg;
        fill_next   = fill_reg;
        total_next  = total_reg;
        cnt_next    = cnt_reg;
        rd_vld_next = 1'b0;
        rd_run_next = rd_run_reg;
        have_next   = have_reg;
        best_next   = best_reg;
        src_next    = src_reg;
        res_next    = res_reg;
        mem_req     = '0;

        // running minimum over the head read of the previous cycle
        if (rd_vld_reg && (!have_reg || (rank_new < rank_best))) begin
            have_next = 1'b1;
            best_next = mem_rd_data;
            src_next  = rd_run_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next = in_item;
                    have_next = 1'b0;
                    cnt_next  = '0;
                    state_next = (in_item.func == FUNC_POP) ? ST_SCAN : ST_PUSH;
                end
            end
            ST_PUSH: begin
                res_next = '0;
                if (push_ok) begin
                    mem_req.we           = 1'b1;
                    mem_req.waddr        = {push_run, push_pos};
                    mem_req.wdata        = KEY_BITS'(item_reg.key_in);
                    fill_next[push_run]  = fill_reg[push_run] + 1'b1;
                    total_next           = total_reg + 1'b1;
                end
                res_next.rejected  = !push_ok;
                res_next.remaining = REMAIN_W'(push_ok ? total_reg + 1'b1 : total_reg);
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                // one head read per run
                mem_req.re  = 1'b1;
                mem_req.raddr = {cnt_reg, ptr_reg[cnt_reg]};
                rd_vld_next = (fill_reg[cnt_reg] != '0);
                rd_run_next = cnt_reg;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == RUN_BITS'(NUM_RUNS - 1)) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                res_next = '0;
                if (have_reg) begin
                    ptr_next[src_reg]  = ptr_reg[src_reg] + 1'b1;
                    fill_next[src_reg] = fill_reg[src_reg] - 1'b1;
                    total_next         = total_reg - 1'b1;
                    res_next.found      = 1'b1;
                    res_next.key_out    = KEY_W'(best_reg);
                    res_next.source_run = RUN_ID_W'(src_reg);
                end
                res_next.remaining = REMAIN_W'(have_reg ? total_reg - 1'b1 : total_reg);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            total_reg  <= '0;
            rd_vld_reg <= 1'b0;
            have_reg   <= 1'b0;
            cnt_reg    <= '0;
            for (int i = 0; i < NUM_RUNS; i++) begin
                ptr_reg[i]  <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            rd_vld_reg <= rd_vld_next;
            have_reg   <= have_next;
            cnt_reg    <= cnt_next;
            ptr_reg    <= ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        rd_run_reg <= rd_run_next;
        best_reg   <= best_next;
        src_reg    <= src_next;
        res_reg    <= res_next;
    end

endmodule

@@ design/kwm_checker.sv @@
// kwm_checker: port-level assertions for k_way_sorted_run_merge_top, with its bind
// depends on kwm_pkg

module kwm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [kwm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kwm_pkg::PDATA_W-1:0]   prdata
);
    import kwm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a request cannot both pop a key and be a rejected push
    a_found_rejected: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[35] && m_tdata[36]))
        else $error("found and rejected both set");

    // nothing popped means zero key and run
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[35] |-> (m_tdata[34:0] == '0))
        else $error("key or run set without a pop");

    // held key count never exceeds capacity
    a_remaining_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[46:37]) <= MEM_DEPTH))
        else $error("remaining above capacity");

    // reset clears the compare mode register
    a_cfg_reset: assert property (@(posedge aclk)
        !aresetn |=> (prdata == '0))
        else $error("register not cleared by reset");

endmodule

bind k_way_sorted_run_merge_top kwm_checker u_kwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .prdata   (prdata)
);
